// ===== rtl/core/rsgf_pkg.sv =====
// shared types and constants for the single-gap raster fill block
package rsgf_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int WIDTH_BITS  = 13;
    localparam int HEIGHT_BITS = 16;
    localparam int ROW_BITS    = HEIGHT_BITS + 1;
    localparam int SAMPLE_BITS = 32;
    localparam int FRAC_BITS   = 3;
    localparam int RESULT_BITS = SAMPLE_BITS + FRAC_BITS;
    localparam int CFG_BITS    = 16;
    localparam int INDEX_BITS  = 1;

    // configuration register indexes
    localparam logic [INDEX_BITS-1:0] REG_GRID_WIDTH  = 1'd0;
    localparam logic [INDEX_BITS-1:0] REG_GRID_HEIGHT = 1'd1;

    // command codes
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // one grid cell: sample plus no-data flag
    typedef struct packed {
        logic                          miss;
        logic signed [SAMPLE_BITS-1:0] val;
    } cell_t;

    // one line store entry: the cell two rows up and the cell one row up
    typedef struct packed {
        cell_t older;
        cell_t newer;
    } col_pair_t;

endpackage

// ===== rtl/core/rsgf_line_store.sv =====
// two-row line store: one entry per column, one read and one write per cycle
module rsgf_line_store (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [rsgf_pkg::COL_BITS-1:0] rd_addr,
    output rsgf_pkg::col_pair_t         rd_data,
    input  logic                        wr_en,
    input  logic [rsgf_pkg::COL_BITS-1:0] wr_addr,
    input  rsgf_pkg::col_pair_t         wr_data
);
    import rsgf_pkg::*;

    col_pair_t mem [MAX_WIDTH];
    col_pair_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/raster_single_gap_fill_top.sv =====
// top level of the single-gap raster fill block
// Pixels enter in raster order at up to one beat per clock and results leave at up to one beat
// per clock; the beat that completes a result's 3x3 neighbourhood comes one row plus one pixel
// after the pixel itself, and the result is registered. Each accepted beat reads and writes
// one column of a 4096-entry, 66-bit line store (one read port, one write port), which is what
// holds the rate at one beat per clock. After the last pixel of a frame send grid_width+1 more
// beats (flush or pixel, their data is dropped) to drain it; a flush beat sent before the
// frame's pixels are complete is taken and ignored. A register write restarts the frame.
// The line store is not cleared after reset and needs no clearing time.
module raster_single_gap_fill_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration
    input  logic                                  cfg_we,
    input  logic [rsgf_pkg::INDEX_BITS-1:0]       cfg_index,
    input  logic [rsgf_pkg::CFG_BITS-1:0]         cfg_data,
    // input beats
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  command,
    input  logic signed [rsgf_pkg::SAMPLE_BITS-1:0] pixel_value,
    input  logic                                  pixel_missing,
    // result beats
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [rsgf_pkg::RESULT_BITS-1:0] result_value,
    output logic                                  result_missing,
    output logic                                  frame_end
);
    import rsgf_pkg::*;

    // configuration registers
    logic [WIDTH_BITS-1:0]  grid_width_reg;
    logic [HEIGHT_BITS-1:0] grid_height_reg;
    logic [WIDTH_BITS-1:0]  w_eff;
    logic [HEIGHT_BITS-1:0] h_eff;

    // input position counters
    logic [COL_BITS-1:0] in_col_reg, in_col_next;
    logic [ROW_BITS-1:0] in_row_reg, in_row_next;

    // stage 0 decode
    logic                   in_fire;
    logic                   pixel_phase;
    logic                   take;
    logic                   s0_emit;
    logic [COL_BITS-1:0]    s0_cx;
    logic [HEIGHT_BITS-1:0] s0_cy;
    logic                   s0_last;
    logic                   s0_interior;
    logic [WIDTH_BITS-1:0]  col_plus;
    cell_t                  s0_p;

    // stage 1 registers
    logic                s1_valid_reg;
    logic                s1_emit_reg;
    logic                s1_last_reg;
    logic                s1_interior_reg;
    logic                s1_fwd_reg;
    logic [COL_BITS-1:0] s1_col_reg;
    cell_t               s1_p_reg;
    logic                s1_go;

    // last pair written to the line store, for same-column forwarding
    cell_t     wr_b_reg;
    cell_t     wr_p_reg;
    col_pair_t rd_pair;
    col_pair_t wr_pair;
    cell_t     new_a;
    cell_t     new_b;

    // 3x3 window
    cell_t win_reg [3][3];

    // result computation
    cell_t                         ctr;
    logic                          nb_miss;
    logic signed [RESULT_BITS-1:0] nb_sum;
    logic signed [RESULT_BITS-1:0] res_value;
    logic                          res_miss;

    // output register
    logic                          out_valid_reg;
    logic signed [RESULT_BITS-1:0] result_value_reg;
    logic                          result_missing_reg;
    logic                          frame_end_reg;

    // effective grid size
    always_comb
    begin
        if (grid_width_reg == '0)
        begin
            w_eff = WIDTH_BITS'(1);
        end
        else if (grid_width_reg > WIDTH_BITS'(MAX_WIDTH))
        begin
            w_eff = WIDTH_BITS'(MAX_WIDTH);
        end
        else
        begin
            w_eff = grid_width_reg;
        end
        h_eff = (grid_height_reg == '0) ? HEIGHT_BITS'(1) : grid_height_reg;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= WIDTH_BITS'(4096);
            grid_height_reg <= HEIGHT_BITS'(4096);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_data[WIDTH_BITS-1:0];
                REG_GRID_HEIGHT: grid_height_reg <= cfg_data[HEIGHT_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // stage 0: position decode for the incoming beat
    always_comb
    begin
        in_fire     = in_valid && in_ready;
        pixel_phase = in_row_reg < {1'b0, h_eff};
        take        = in_fire && !(pixel_phase && (command == CMD_FLUSH));
        s0_emit     = (in_row_reg >= ROW_BITS'(2)) ||
                      ((in_row_reg == ROW_BITS'(1)) && (in_col_reg != '0));
        if (in_col_reg == '0)
        begin
            s0_cx = COL_BITS'(w_eff - WIDTH_BITS'(1));
            s0_cy = HEIGHT_BITS'(in_row_reg - ROW_BITS'(2));
        end
        else
        begin
            s0_cx = in_col_reg - COL_BITS'(1);
            s0_cy = HEIGHT_BITS'(in_row_reg - ROW_BITS'(1));
        end
        s0_last     = s0_emit && (s0_cy == h_eff - HEIGHT_BITS'(1)) &&
                      ({1'b0, s0_cx} == w_eff - WIDTH_BITS'(1));
        s0_interior = (s0_cx != '0) && (({1'b0, s0_cx} + WIDTH_BITS'(1)) < w_eff) &&
                      (s0_cy != '0) &&
                      (({1'b0, s0_cy} + ROW_BITS'(1)) < {1'b0, h_eff});
        col_plus    = {1'b0, in_col_reg} + WIDTH_BITS'(1);
        if (pixel_phase)
        begin
            s0_p.miss = pixel_missing;
            s0_p.val  = pixel_value;
        end
        else
        begin
            s0_p.miss = 1'b1;
            s0_p.val  = '0;
        end
    end

    // position counters
    always_comb
    begin
        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        if (cfg_we || (take && s0_last))
        begin
            in_col_next = '0;
            in_row_next = '0;
        end
        else if (take)
        begin
            if (col_plus >= w_eff)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROW_BITS'(1);
            end
            else
            begin
                in_col_next = col_plus[COL_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg <= '0;
            in_row_reg <= '0;
        end
        else
        begin
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
        end
    end

    // stage 1 advances unless its result cannot be placed
    assign s1_go    = s1_valid_reg && (!s1_emit_reg || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_go;

    // stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_emit_reg     <= s0_emit;
            s1_last_reg     <= s0_last;
            s1_interior_reg <= s0_interior;
            s1_col_reg      <= in_col_reg;
            s1_p_reg        <= s0_p;
            s1_fwd_reg      <= s1_valid_reg && (s1_col_reg == in_col_reg);
        end
        if (s1_go)
        begin
            wr_b_reg <= new_b;
            wr_p_reg <= s1_p_reg;
        end
    end

    // line store
    rsgf_line_store u_line_store (
        .clk     (clk),
        .rd_en   (take),
        .rd_addr (in_col_reg),
        .rd_data (rd_pair),
        .wr_en   (s1_go),
        .wr_addr (s1_col_reg),
        .wr_data (wr_pair)
    );

    // forward the previous beat's write when both hit the same column
    always_comb
    begin
        new_a         = s1_fwd_reg ? wr_b_reg : rd_pair.older;
        new_b         = s1_fwd_reg ? wr_p_reg : rd_pair.newer;
        wr_pair.older = new_b;
        wr_pair.newer = s1_p_reg;
    end

    // window shift, cleared at frame restart
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '{miss: 1'b1, val: '0};
                end
            end
        end
        else if (cfg_we || (s1_go && s1_last_reg))
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '{miss: 1'b1, val: '0};
                end
            end
        end
        else if (s1_go)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= new_a;
            win_reg[1][2] <= new_b;
            win_reg[2][2] <= s1_p_reg;
        end
    end

    // result from the window as it stands after this beat's shift
    always_comb
    begin
        ctr     = win_reg[1][2];
        nb_miss = win_reg[0][1].miss || win_reg[0][2].miss || new_a.miss ||
                  win_reg[1][1].miss || new_b.miss ||
                  win_reg[2][1].miss || win_reg[2][2].miss || s1_p_reg.miss;
        nb_sum  = RESULT_BITS'(win_reg[0][1].val) + RESULT_BITS'(win_reg[0][2].val) +
                  RESULT_BITS'(new_a.val) + RESULT_BITS'(win_reg[1][1].val) +
                  RESULT_BITS'(new_b.val) + RESULT_BITS'(win_reg[2][1].val) +
                  RESULT_BITS'(win_reg[2][2].val) + RESULT_BITS'(s1_p_reg.val);
        if (!ctr.miss)
        begin
            res_value = {ctr.val, {FRAC_BITS{1'b0}}};
            res_miss  = 1'b0;
        end
        else if (s1_interior_reg && !nb_miss)
        begin
            res_value = nb_sum;
            res_miss  = 1'b0;
        end
        else
        begin
            res_value = '0;
            res_miss  = 1'b1;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && s1_emit_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_emit_reg)
        begin
            result_value_reg   <= res_value;
            result_missing_reg <= res_miss;
            frame_end_reg      <= s1_last_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_value   = result_value_reg;
    assign result_missing = result_missing_reg;
    assign frame_end      = frame_end_reg;

    // forwarding only happens at width one or on column zero right after a frame restart
    a_fwd_same_column: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_fwd_reg) |-> ((w_eff == WIDTH_BITS'(1)) || (s1_col_reg == '0)))
        else $error("same-column forwarding away from column zero with width above one");

    // a stalled stage 1 must block new beats
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_go) |-> !in_ready)
        else $error("input taken while stage 1 is stalled");

    // column counter stays inside the row
    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, in_col_reg} < w_eff) || $past(cfg_we))
        else $error("column counter beyond grid width");

    // the frame's last beat restarts the position counters
    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (take && s0_last) |=> ((in_col_reg == '0) && (in_row_reg == '0)))
        else $error("counters not cleared after frame end");

    // a held result is not overwritten
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(result_value_reg) &&
                                           $stable(frame_end_reg)))
        else $error("pending result changed before it was taken");

endmodule

// ===== dv/tb.sv =====
// self-checking testbench for the single-gap raster fill block
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rsgf_pkg::*;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam int SETTLE_CYCLES = 8;

    // one input beat as sent
    typedef struct packed {
        logic                          cmd;
        logic signed [SAMPLE_BITS-1:0] val;
        logic                          miss;
    } pix_beat_t;

    // one output cell as predicted
    typedef struct packed {
        logic signed [RESULT_BITS-1:0] val;
        logic                          miss;
        logic                          last;
    } fill_cell_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [INDEX_BITS-1:0]         cfg_index = '0;
    logic [CFG_BITS-1:0]           cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic                          command = CMD_PIXEL;
    logic signed [SAMPLE_BITS-1:0] pixel_value = '0;
    logic                          pixel_missing = 1'b0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic signed [RESULT_BITS-1:0] result_value;
    logic                          result_missing;
    logic                          frame_end;

    // beats waiting to be sent and cells waiting to come out
    pix_beat_t  pixel_beats[$];
    fill_cell_t expected_cells[$];

    // predictor copy of the block state
    cell_t row_older [MAX_WIDTH];
    cell_t row_newer [MAX_WIDTH];
    cell_t nbhd [3][3];
    int    col_in;
    int    row_in;
    int    grid_w = MAX_WIDTH;
    int    grid_h = 4096;

    // bookkeeping
    int        mismatches = 0;
    int        beats_taken = 0;
    int        results_seen = 0;
    int        frames_closed = 0;
    int        cells_filled = 0;
    int        send_wait = 0;
    int        take_wait = 0;
    pix_beat_t cur_beat;

    raster_single_gap_fill_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .pixel_value    (pixel_value),
        .pixel_missing  (pixel_missing),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_value   (result_value),
        .result_missing (result_missing),
        .frame_end      (frame_end)
    );

    // clock
    always #5 clk = ~clk;

    function automatic int eff_width();
        if (grid_w == 0)
            return 1;
        if (grid_w > MAX_WIDTH)
            return MAX_WIDTH;
        return grid_w;
    endfunction

    function automatic int eff_height();
        return (grid_h == 0) ? 1 : grid_h;
    endfunction

    // counters to zero, window all no-data
    function automatic void restart_frame();
        col_in = 0;
        row_in = 0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
            begin
                nbhd[r][c].miss = 1'b1;
                nbhd[r][c].val  = '0;
            end
    endfunction

    // advance the line stores and window by one beat, queue the cell it completes
    task automatic gap_fill_step(input pix_beat_t b);
        int         w;
        int         h;
        int         cx;
        int         cy;
        bit         emit;
        bit         hole;
        cell_t      p;
        cell_t      up2;
        cell_t      up1;
        cell_t      ctr;
        logic signed [RESULT_BITS-1:0] acc;
        fill_cell_t res;
        w = eff_width();
        h = eff_height();
        // flush while pixels are still due: dropped
        if (row_in < h && b.cmd == CMD_FLUSH)
            return;
        if (row_in < h)
        begin
            p.miss = b.miss;
            p.val  = b.val;
        end
        else
        begin
            p.miss = 1'b1;
            p.val  = '0;
        end
        emit = (row_in >= 2) || (row_in == 1 && col_in >= 1);
        cx = 0;
        cy = 0;
        if (emit)
        begin
            if (col_in == 0)
            begin
                cy = row_in - 2;
                cx = w - 1;
            end
            else
            begin
                cy = row_in - 1;
                cx = col_in - 1;
            end
        end
        // line stores and window shift
        up2 = row_older[col_in];
        up1 = row_newer[col_in];
        row_older[col_in] = up1;
        row_newer[col_in] = p;
        for (int r = 0; r < 3; r++)
        begin
            nbhd[r][0] = nbhd[r][1];
            nbhd[r][1] = nbhd[r][2];
        end
        nbhd[0][2] = up2;
        nbhd[1][2] = up1;
        nbhd[2][2] = p;
        col_in++;
        if (col_in >= w)
        begin
            col_in = 0;
            row_in++;
        end
        if (!emit)
            return;
        // center cell: pass through, fill from neighbours, or stay no-data
        ctr  = nbhd[1][1];
        acc  = '0;
        hole = 1'b0;
        if (!ctr.miss)
        begin
            acc = ctr.val;
            acc = acc <<< FRAC_BITS;
        end
        else if (cx >= 1 && cx + 1 < w && cy >= 1 && cy + 1 < h)
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    if (!(r == 1 && c == 1))
                    begin
                        if (nbhd[r][c].miss)
                            hole = 1'b1;
                        acc = acc + nbhd[r][c].val;
                    end
            if (hole)
                acc = '0;
            else
                cells_filled++;
        end
        else
        begin
            hole = 1'b1;
        end
        res.val  = acc;
        res.miss = hole;
        res.last = (cy == h - 1) && (cx == w - 1);
        expected_cells.push_back(res);
        if (res.last)
        begin
            frames_closed++;
            restart_frame();
        end
    endtask

    // input driver: one beat at a time from the pending queue
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                gap_fill_step(cur_beat);
                beats_taken++;
                send_wait = ((beats_taken / 50) % 4 == 0) ? 0 : $urandom_range(0, 4);
            end
            if (!in_valid || in_ready)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    in_valid <= 1'b0;
                end
                else if (pixel_beats.size() > 0)
                begin
                    cur_beat = pixel_beats.pop_front();
                    in_valid      <= 1'b1;
                    command       <= cur_beat.cmd;
                    pixel_value   <= cur_beat.val;
                    pixel_missing <= cur_beat.miss;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random stalls
    always @(posedge clk)
    begin
        fill_cell_t exp_cell;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_cells.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: value %0d missing %0b end %0b",
                                 result_value, result_missing, frame_end);
                end
                else
                begin
                    exp_cell = expected_cells.pop_front();
                    if (result_value !== exp_cell.val || result_missing !== exp_cell.miss
                        || frame_end !== exp_cell.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: expected %0d/%0b/%0b got %0d/%0b/%0b",
                                     results_seen, exp_cell.val, exp_cell.miss,
                                     exp_cell.last, result_value, result_missing,
                                     frame_end);
                    end
                end
                take_wait = ((results_seen / 40) % 3 == 0) ? 0 : $urandom_range(0, 4);
            end
            if (take_wait > 0)
            begin
                take_wait--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic push_beat(input logic cmd, input logic signed [SAMPLE_BITS-1:0] val,
                             input logic miss);
        pix_beat_t b;
        b.cmd  = cmd;
        b.val  = val;
        b.miss = miss;
        pixel_beats.push_back(b);
    endtask

    // wait until every beat is in and every predicted cell is out
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pixel_beats.size() != 0 || in_valid || expected_cells.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // register write, mirrored into the predictor
    task automatic write_reg(input logic [INDEX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == REG_GRID_WIDTH)
            grid_w = data[WIDTH_BITS-1:0];
        else
            grid_h = data[HEIGHT_BITS-1:0];
        restart_frame();
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(
        input int style, input logic signed [SAMPLE_BITS-1:0] level);
        case (style)
            0: return $urandom;
            1:
            begin
                case ($urandom_range(0, 4))
                    0: return SAMPLE_MAX;
                    1: return SAMPLE_MIN;
                    2: return '0;
                    3: return '1;
                    default: return $urandom;
                endcase
            end
            2: return ($urandom_range(0, 7) == 0) ? $urandom : level;
            default: return int'($urandom_range(0, 15)) - 8;
        endcase
    endfunction

    // queue one frame; cut stops it early, pause_at waits for the block to drain
    task automatic queue_frame(input int w, input int h, input int cut, input int pause_at);
        int   style;
        int   miss_div;
        int   i;
        logic signed [SAMPLE_BITS-1:0] level;
        style = $urandom_range(0, 3);
        case ($urandom_range(0, 3))
            0: miss_div = 2;
            1: miss_div = 4;
            2: miss_div = 6;
            default: miss_div = 12;
        endcase
        level = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
        for (i = 0; i < w * h && i < cut; i++)
        begin
            if (i == pause_at)
                wait_idle();
            // stray flush mid-frame
            if ($urandom_range(0, 15) == 0)
                push_beat(CMD_FLUSH, $urandom, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, miss_div - 1) == 0)
                push_beat(CMD_PIXEL, $urandom, 1'b1);
            else
                push_beat(CMD_PIXEL, pick_sample(style, level), 1'b0);
        end
        // drain with a mix of flush and pixel beats
        if (cut >= w * h)
            for (i = 0; i <= w; i++)
                push_beat(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)));
    endtask

    // stimulus
    initial
    begin
        int w;
        int h;
        int nframes;
        int cut;
        int pause_at;
        int random_items;
        int guard;
        for (int k = 0; k < MAX_WIDTH; k++)
        begin
            row_older[k] = '0;
            row_newer[k] = '0;
        end
        restart_frame();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed 5x3 frame: fill at max, gap next to a border gap, border gap
        write_reg(REG_GRID_WIDTH, 16'd5);
        write_reg(REG_GRID_HEIGHT, 16'd3);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 5; c++)
            begin
                if (r == 1 && c == 2)
                    push_beat(CMD_FLUSH, SAMPLE_MIN, 1'b1);
                if ((r == 1 && (c == 1 || c == 3)) || (r == 0 && c == 4))
                    push_beat(CMD_PIXEL, $urandom, 1'b1);
                else
                    push_beat(CMD_PIXEL, (c <= 2) ? SAMPLE_MAX : SAMPLE_MIN, 1'b0);
            end
        for (int k = 0; k <= 5; k++)
            push_beat((k % 2 == 0) ? CMD_FLUSH : CMD_PIXEL, $urandom, k[1]);
        wait_idle();

        // saturated width, frame cut short and paused partway for a full drain
        write_reg(REG_GRID_WIDTH, 16'hFFFF);
        write_reg(REG_GRID_HEIGHT, 16'd3);
        queue_frame(MAX_WIDTH, 3, 40, 20);
        wait_idle();

        // zero registers act as one
        write_reg(REG_GRID_WIDTH, 16'd0);
        write_reg(REG_GRID_HEIGHT, 16'd0);
        repeat (3) queue_frame(1, 1, 1, -1);
        wait_idle();

        // narrow grids, the first 2x3 frame paused partway for a full drain
        write_reg(REG_GRID_WIDTH, 16'd1);
        write_reg(REG_GRID_HEIGHT, 16'd7);
        queue_frame(1, 7, 7, -1);
        wait_idle();
        write_reg(REG_GRID_WIDTH, 16'd2);
        write_reg(REG_GRID_HEIGHT, 16'd3);
        queue_frame(2, 3, 6, 4);
        queue_frame(2, 3, 6, -1);
        wait_idle();

        // tallest grid, abandoned partway by the next register write
        write_reg(REG_GRID_WIDTH, 16'd3);
        write_reg(REG_GRID_HEIGHT, 16'hFFFF);
        queue_frame(3, 65535, 20, -1);
        wait_idle();

        // random grids and frames
        random_items = 0;
        while (random_items < 430)
        begin
            case ($urandom_range(0, 9))
                0: w = $urandom_range(1, 2);
                1: w = $urandom_range(20, 48);
                default: w = $urandom_range(3, 12);
            endcase
            h = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 6);
            write_reg(REG_GRID_WIDTH,
                      CFG_BITS'(($urandom_range(0, 3) == 0) ? (w | 'hE000) : w));
            write_reg(REG_GRID_HEIGHT, CFG_BITS'(h));
            nframes = $urandom_range(1, 3);
            for (int f = 0; f < nframes; f++)
            begin
                cut = w * h;
                if (f == nframes - 1 && w * h > 1 && $urandom_range(0, 5) == 0)
                    cut = $urandom_range(1, w * h - 1);
                pause_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, w * h - 1) : -1;
                queue_frame(w, h, cut, pause_at);
                random_items += (cut < w * h) ? cut : w * h + w + 1;
            end
            wait_idle();
        end

        // final drain, bounded
        guard = 0;
        while ((pixel_beats.size() != 0 || in_valid || expected_cells.size() != 0)
               && guard < 100000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (20) @(negedge clk);
        if (expected_cells.size() != 0)
        begin
            mismatches += expected_cells.size();
            $display("%0d expected result beats never arrived", expected_cells.size());
        end
        $display("run covered %0d input beats, %0d result beats, %0d frames, %0d cells filled",
                 beats_taken, results_seen, frames_closed, cells_filled);
        $display("grid widths 1 to %0d, heights 1 to 65535, %0d mismatches",
                 MAX_WIDTH, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/rsgf_pkg.sv
rtl/core/rsgf_line_store.sv
rtl/core/raster_single_gap_fill_top.sv
dv/tb.sv
